[rtl/spl_pkg.sv]
// Shared widths, reset values and register map of the stereo peak limiter.
// No dependencies; the limiter core refers to everything here by scoped name.

package spl_pkg;

    localparam int SampleW = 24;
    localparam int CoefW   = 16;
    localparam int GainW   = 17;
    localparam int AddrW   = 4;
    localparam int DataW   = 32;

    // Counter loads for the serial loops (count down to zero).
    localparam logic [4:0] DivLast   = 5'd15;
    localparam logic [4:0] CoefLast  = 5'd15;
    localparam logic [4:0] SmpLast   = 5'd23;

    localparam logic [GainW-1:0]  UnityGain    = 17'd65536;
    localparam logic [CoefW-1:0]  ThreshReset  = 16'd36853;
    localparam logic [CoefW-1:0]  ReleaseReset = 16'd65506;
    localparam logic [CoefW-1:0]  MakeupReset  = 16'd16384;

    localparam logic [SampleW-1:0] OutMax    = 24'h7FFFFF;
    localparam logic [SampleW-1:0] OutMinMag = 24'h800000;

    typedef enum logic [1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_RELEASE   = 2'd2,
        CFG_MAKEUP    = 2'd3
    } cfg_idx_t;

endpackage

[rtl/stereo_peak_limiter.sv]
// Stereo peak limiter with instant attack and one-pole release, bit-serial datapath.
// Depends on spl_pkg for widths, reset values and the register map.
//
//  channel   | direction | width | beat contents
//  ----------+-----------+-------+--------------------------------------------------
//  s_axis    | in        | 48    | tdata[23:0] left_in, tdata[47:24] right_in
//  m_axis    | out       | 48    | tdata[23:0] left_out, tdata[47:24] right_out
//  apb       | in/out    | 32    | reg 0 enable, 1 threshold, 2 release, 3 makeup
//
// A limited frame passes through these steps in order before it reaches the output register:
// the restoring division when the peak is over the threshold, picking the gain, the release
// multiply and its update (skipped on attack), gain times makeup, the load, the sample
// multiplies (one magnitude bit per cycle) and the rounding. A frame taken while the limiter
// is disabled goes straight to the output register. Frames are processed one at a time;
// a finished frame holds the input off while the output register still waits for
// m_axis_tready. Reset restores the register defaults and sets the smoothed gain to unity.

module stereo_peak_limiter
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [2*spl_pkg::SampleW-1:0] s_axis_tdata,  // [23:0] left_in, [47:24] right_in

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [2*spl_pkg::SampleW-1:0] m_axis_tdata,  // [23:0] left_out, [47:24] right_out

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spl_pkg::AddrW-1:0]   paddr,
    input  logic [spl_pkg::DataW-1:0]   pwdata,
    output logic [spl_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_GAIN,
        ST_REL,
        ST_RUPD,
        ST_GMK,
        ST_SLD,
        ST_SCL,
        ST_FIN
    } state_t;

    localparam int SW = spl_pkg::SampleW;
    localparam int CW = spl_pkg::CoefW;
    localparam int GW = spl_pkg::GainW;
    localparam int MW = GW + CW;          // gain times makeup

    // Control and configuration.
    state_t          state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            enable_reg, enable_next;
    logic [CW-1:0]   thr_reg, thr_next;
    logic [CW-1:0]   rel_reg, rel_next;
    logic [CW-1:0]   mk_reg, mk_next;
    logic [GW-1:0]   gain_reg, gain_next;
    logic            bypass_reg, bypass_next;
    logic            out_valid_reg, out_valid_next;

    // Frame payload.
    logic [SW-1:0]   left_reg, left_next;
    logic [SW-1:0]   right_reg, right_next;
    logic [SW-1:0]   peak_reg, peak_next;
    logic [SW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   quo_reg, quo_next;
    logic [GW-1:0]   target_reg, target_next;

    // Coefficient multiplier: 17-bit multiplicand, 16-bit multiplier.
    logic [GW-1:0]   a_mc_reg, a_mc_next;
    logic [CW-1:0]   a_mp_reg, a_mp_next;
    logic [GW-1:0]   a_hi_reg, a_hi_next;
    logic [CW-1:0]   a_lo_reg, a_lo_next;

    // Sample multipliers: 33-bit gain product times 24-bit magnitude, one per channel.
    logic [MW-1:0]   gm_reg, gm_next;
    logic [SW-1:0]   ml_reg, ml_next;
    logic [SW-1:0]   mr_reg, mr_next;
    logic [MW-1:0]   lhi_reg, lhi_next;
    logic [SW-1:0]   llo_reg, llo_next;
    logic [MW-1:0]   rhi_reg, rhi_next;
    logic [SW-1:0]   rlo_reg, rlo_next;

    logic [SW-1:0]   out_l_reg, out_l_next;
    logic [SW-1:0]   out_r_reg, out_r_next;

    // Combinational helpers.
    logic [SW-1:0]   in_l, in_r, mag_l, mag_r, mag_max;
    logic            in_fire, cfg_wr, over_thr;
    logic [SW:0]     rem_sh;
    logic            rem_ge;
    logic [GW:0]     a_sum;
    logic [MW:0]     l_sum, r_sum;
    logic [MW:0]     rel_acc;
    logic [GW-1:0]   rel_gain;
    logic            out_free;

    // Round half away from zero at bit 30 and saturate, on sign-magnitude product.
    function automatic logic [SW-1:0] round_sat(input logic [MW-1:0] hi,
                                                input logic [SW-1:0] lo,
                                                input logic neg);
        logic [MW+SW-1:0] prod;
        logic [27:0]      r;
        logic [SW-1:0]    res;
        prod = {hi, lo};
        r = {1'b0, prod[MW+SW-1:30]} + {27'd0, prod[29]};
        if (neg) begin
            if (r > {4'd0, spl_pkg::OutMinMag}) begin
                r = {4'd0, spl_pkg::OutMinMag};
            end
            res = ~r[SW-1:0] + 1'b1;
        end else begin
            if (r > {4'd0, spl_pkg::OutMax}) begin
                r = {4'd0, spl_pkg::OutMax};
            end
            res = r[SW-1:0];
        end
        return res;
    endfunction

    assign in_l  = s_axis_tdata[SW-1:0];
    assign in_r  = s_axis_tdata[2*SW-1:SW];
    assign mag_l = in_l[SW-1] ? (~in_l + 1'b1) : in_l;
    assign mag_r = in_r[SW-1] ? (~in_r + 1'b1) : in_r;
    assign mag_max  = (mag_l > mag_r) ? mag_l : mag_r;
    assign over_thr = mag_max > {1'b0, thr_reg, 7'd0};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // One quotient bit per cycle.
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, peak_reg};

    // One multiplier bit per cycle, product shifted out to the right.
    assign a_sum = {1'b0, a_hi_reg} + (a_mp_reg[0] ? {1'b0, a_mc_reg} : '0);
    assign l_sum = {1'b0, lhi_reg} + (ml_reg[0] ? {1'b0, gm_reg} : '0);
    assign r_sum = {1'b0, rhi_reg} + (mr_reg[0] ? {1'b0, gm_reg} : '0);

    // Release: g' = ceil((t*2^16 - (t-g)*a) / 2^16), never above unity.
    assign rel_acc  = {1'b0, target_reg, 16'd0} - {1'b0, a_hi_reg, a_lo_reg} + (MW+1)'(65535);
    assign rel_gain = (rel_acc[MW-1:16] > spl_pkg::UnityGain) ? spl_pkg::UnityGain
                                                               : rel_acc[MW-1:16];

    always_comb
    begin
        prdata = '0;
        case (spl_pkg::cfg_idx_t'(paddr[3:2]))
            spl_pkg::CFG_ENABLE:    prdata = {31'd0, enable_reg};
            spl_pkg::CFG_THRESHOLD: prdata = {16'd0, thr_reg};
            spl_pkg::CFG_RELEASE:   prdata = {16'd0, rel_reg};
            spl_pkg::CFG_MAKEUP:    prdata = {16'd0, mk_reg};
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        enable_next    = enable_reg;
        thr_next       = thr_reg;
        rel_next       = rel_reg;
        mk_next        = mk_reg;
        gain_next      = gain_reg;
        bypass_next    = bypass_reg;
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        peak_next      = peak_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        target_next    = target_reg;
        a_mc_next      = a_mc_reg;
        a_mp_next      = a_mp_reg;
        a_hi_next      = a_hi_reg;
        a_lo_next      = a_lo_reg;
        gm_next        = gm_reg;
        ml_next        = ml_reg;
        mr_next        = mr_reg;
        lhi_next       = lhi_reg;
        llo_next       = llo_reg;
        rhi_next       = rhi_reg;
        rlo_next       = rlo_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;

        if (cfg_wr) begin
            case (spl_pkg::cfg_idx_t'(paddr[3:2]))
                spl_pkg::CFG_ENABLE:    enable_next = pwdata[0];
                spl_pkg::CFG_THRESHOLD: thr_next    = pwdata[CW-1:0];
                spl_pkg::CFG_RELEASE:   rel_next    = pwdata[CW-1:0];
                spl_pkg::CFG_MAKEUP:    mk_next     = pwdata[CW-1:0];
                default:                ;
            endcase
        end

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    left_next   = in_l;
                    right_next  = in_r;
                    ml_next     = mag_l;
                    mr_next     = mag_r;
                    peak_next   = mag_max;
                    bypass_next = !enable_reg;
                    rem_next    = {1'b0, thr_reg, 7'd0};
                    quo_next    = '0;
                    target_next = spl_pkg::UnityGain;
                    cnt_next    = spl_pkg::DivLast;
                    if (!enable_reg) begin
                        state_next = ST_FIN;
                    end else if (over_thr) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_GAIN;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next = rem_ge ? SW'(rem_sh - {1'b0, peak_reg}) : rem_sh[SW-1:0];
                quo_next = {quo_reg[CW-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    target_next = {1'b0, quo_next};
                    state_next  = ST_GAIN;
                end
            end

            ST_GAIN:
            begin
                a_hi_next = '0;
                a_lo_next = '0;
                cnt_next  = spl_pkg::CoefLast;
                if (target_reg < gain_reg) begin
                    // Attack: take the lower target at once.
                    gain_next  = target_reg;
                    a_mc_next  = target_reg;
                    a_mp_next  = mk_reg;
                    state_next = ST_GMK;
                end else begin
                    a_mc_next  = target_reg - gain_reg;
                    a_mp_next  = rel_reg;
                    state_next = ST_REL;
                end
            end

            ST_REL, ST_GMK:
            begin
                a_hi_next = a_sum[GW:1];
                a_lo_next = {a_sum[0], a_lo_reg[CW-1:1]};
                a_mp_next = a_mp_reg >> 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = (state_reg == ST_REL) ? ST_RUPD : ST_SLD;
                end
            end

            ST_RUPD:
            begin
                gain_next  = rel_gain;
                a_mc_next  = rel_gain;
                a_mp_next  = mk_reg;
                a_hi_next  = '0;
                a_lo_next  = '0;
                cnt_next   = spl_pkg::CoefLast;
                state_next = ST_GMK;
            end

            ST_SLD:
            begin
                gm_next    = {a_hi_reg, a_lo_reg};
                lhi_next   = '0;
                llo_next   = '0;
                rhi_next   = '0;
                rlo_next   = '0;
                cnt_next   = spl_pkg::SmpLast;
                state_next = ST_SCL;
            end

            ST_SCL:
            begin
                lhi_next = l_sum[MW:1];
                llo_next = {l_sum[0], llo_reg[SW-1:1]};
                rhi_next = r_sum[MW:1];
                rlo_next = {r_sum[0], rlo_reg[SW-1:1]};
                ml_next  = ml_reg >> 1;
                mr_next  = mr_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free) begin
                    if (bypass_reg) begin
                        out_l_next = left_reg;
                        out_r_next = right_reg;
                    end else begin
                        out_l_next = round_sat(lhi_reg, llo_reg, left_reg[SW-1]);
                        out_r_next = round_sat(rhi_reg, rlo_reg, right_reg[SW-1]);
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            enable_reg    <= 1'b1;
            thr_reg       <= spl_pkg::ThreshReset;
            rel_reg       <= spl_pkg::ReleaseReset;
            mk_reg        <= spl_pkg::MakeupReset;
            gain_reg      <= spl_pkg::UnityGain;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            enable_reg    <= enable_next;
            thr_reg       <= thr_next;
            rel_reg       <= rel_next;
            mk_reg        <= mk_next;
            gain_reg      <= gain_next;
            bypass_reg    <= bypass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        peak_reg   <= peak_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        target_reg <= target_next;
        a_mc_reg   <= a_mc_next;
        a_mp_reg   <= a_mp_next;
        a_hi_reg   <= a_hi_next;
        a_lo_reg   <= a_lo_next;
        gm_reg     <= gm_next;
        ml_reg     <= ml_next;
        mr_reg     <= mr_next;
        lhi_reg    <= lhi_next;
        llo_reg    <= llo_next;
        rhi_reg    <= rhi_next;
        rlo_reg    <= rlo_next;
        out_l_reg  <= out_l_next;
        out_r_reg  <= out_r_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_r_reg, out_l_reg};

endmodule
